// File: rtl/core/frpc_pkg.sv
// Shared types, constants and fixed-point helpers for the Faraday rotation pixel corrector.
`timescale 1ns / 1ps
`default_nettype none
package frpc_pkg;

    localparam int XY_W   = 34;
    localparam int ANG_W  = 34;
    localparam int PROD_W = 64;
    localparam int ANG_Q  = 30;

    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_xy re;
        t_xy im;
    } t_cplx;

    localparam t_ang PI_Q      = 34'sd3373259426;
    localparam t_ang HALF_PI_Q = 34'sd1686629713;
    localparam t_ang TWO_PI_Q  = 34'sd6746518852;
    localparam t_xy  INV_K_Q   = 34'sd652032874;
    localparam logic [29:0] INV_K_U = 30'd652032874;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORRECT_ENABLE = 2'd0,
        CFG_USE_SINGLE     = 2'd1,
        CFG_SINGLE_ANGLE   = 2'd2
    } t_cfg_idx;

    // atan(2^-k) in Q30 radians
    function automatic t_ang atan_q(input int k);
        t_ang r;
        case (k)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd7;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // fold an angle within two turns back into (-pi, pi]
    function automatic t_ang wrap_pi(input t_ang a);
        t_ang r;
        r = a;
        if (a > PI_Q) begin
            r = a - TWO_PI_Q;
        end else if (a <= -PI_Q) begin
            r = a + TWO_PI_Q;
        end
        return r;
    endfunction

    // shift right by n, rounding half up
    function automatic t_prod rshr(input t_prod v, input int n);
        t_prod r;
        if (n == 0) begin
            r = v;
        end else begin
            r = (v + (t_prod'(1) <<< (n - 1))) >>> n;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/frpc_rot.sv
// Pipelined rotation-mode CORDIC lane: rotate (x, 0) by angle z.
`timescale 1ns / 1ps
`default_nettype none
module frpc_rot import frpc_pkg::*; #(
    parameter int STAGES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_xy  i_x,
    input  wire t_ang i_z,
    output t_cplx     o_v
);

    t_xy  w_x [STAGES+1];
    t_xy  w_y [STAGES+1];
    t_ang w_z [STAGES+1];

    assign w_x[0] = i_x;
    assign w_y[0] = '0;
    assign w_z[0] = i_z;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_xy  r_x, r_y, n_x, n_y;
        t_ang r_z, n_z;

        always_comb begin
            if (!w_z[g][ANG_W-1]) begin
                n_x = w_x[g] - (w_y[g] >>> g);
                n_y = w_y[g] + (w_x[g] >>> g);
                n_z = w_z[g] - atan_q(g);
            end else begin
                n_x = w_x[g] + (w_y[g] >>> g);
                n_y = w_y[g] - (w_x[g] >>> g);
                n_z = w_z[g] + atan_q(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[g+1] = r_x;
        assign w_y[g+1] = r_y;
        assign w_z[g+1] = r_z;
    end

    assign o_v.re = w_x[STAGES];
    assign o_v.im = w_y[STAGES];

endmodule
`default_nettype wire

// File: rtl/core/frpc_mat.sv
// Four-stage R*M*R product and the z12 / z21 estimator terms.
`timescale 1ns / 1ps
`default_nettype none
module frpc_mat import frpc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cplx i_m [4],
    input  wire t_cplx i_cs,
    output t_cplx      o_r [4],
    output t_cplx      o_z12,
    output t_cplx      o_z21
);

    t_prod r1_cre [4], r1_cim [4], r1_sre [4], r1_sim [4];
    t_xy   r1_c, r1_s, r2_c, r2_s;
    t_cplx r1_z12, r1_z21, r2_z12, r2_z21, r3_z12, r3_z21, r4_z12, r4_z21;
    t_cplx r2_p [4];
    t_prod r3_cre [4], r3_cim [4], r3_sre [4], r3_sim [4];
    t_cplx r4_r [4];
    t_xy   w_ar, w_ai, w_br, w_bi;

    always_comb begin
        w_ar = i_m[0].re + i_m[3].re;
        w_ai = i_m[0].im + i_m[3].im;
        w_br = i_m[1].re - i_m[2].re;
        w_bi = i_m[1].im - i_m[2].im;
    end

    // stage 1: c*m and s*m products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_cre[i] <= t_prod'(i_cs.re) * t_prod'(i_m[i].re);
                r1_cim[i] <= t_prod'(i_cs.re) * t_prod'(i_m[i].im);
                r1_sre[i] <= t_prod'(i_cs.im) * t_prod'(i_m[i].re);
                r1_sim[i] <= t_prod'(i_cs.im) * t_prod'(i_m[i].im);
            end
            r1_c      <= i_cs.re;
            r1_s      <= i_cs.im;
            r1_z12.re <= w_br - w_ai;
            r1_z12.im <= w_bi + w_ar;
            r1_z21.re <= -w_br - w_ai;
            r1_z21.im <= -w_bi + w_ar;
        end
    end

    // stage 2: R*M
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p[0].re <= t_xy'(rshr(r1_cre[0] - r1_sre[2], ANG_Q));
            r2_p[0].im <= t_xy'(rshr(r1_cim[0] - r1_sim[2], ANG_Q));
            r2_p[1].re <= t_xy'(rshr(r1_cre[1] - r1_sre[3], ANG_Q));
            r2_p[1].im <= t_xy'(rshr(r1_cim[1] - r1_sim[3], ANG_Q));
            r2_p[2].re <= t_xy'(rshr(r1_sre[0] + r1_cre[2], ANG_Q));
            r2_p[2].im <= t_xy'(rshr(r1_sim[0] + r1_cim[2], ANG_Q));
            r2_p[3].re <= t_xy'(rshr(r1_sre[1] + r1_cre[3], ANG_Q));
            r2_p[3].im <= t_xy'(rshr(r1_sim[1] + r1_cim[3], ANG_Q));
            r2_c   <= r1_c;
            r2_s   <= r1_s;
            r2_z12 <= r1_z12;
            r2_z21 <= r1_z21;
        end
    end

    // stage 3: c*p and s*p products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r3_cre[i] <= t_prod'(r2_c) * t_prod'(r2_p[i].re);
                r3_cim[i] <= t_prod'(r2_c) * t_prod'(r2_p[i].im);
                r3_sre[i] <= t_prod'(r2_s) * t_prod'(r2_p[i].re);
                r3_sim[i] <= t_prod'(r2_s) * t_prod'(r2_p[i].im);
            end
            r3_z12 <= r2_z12;
            r3_z21 <= r2_z21;
        end
    end

    // stage 4: (R*M)*R
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_r[0].re <= t_xy'(rshr(r3_cre[0] + r3_sre[1], ANG_Q));
            r4_r[0].im <= t_xy'(rshr(r3_cim[0] + r3_sim[1], ANG_Q));
            r4_r[1].re <= t_xy'(rshr(r3_cre[1] - r3_sre[0], ANG_Q));
            r4_r[1].im <= t_xy'(rshr(r3_cim[1] - r3_sim[0], ANG_Q));
            r4_r[2].re <= t_xy'(rshr(r3_cre[2] + r3_sre[3], ANG_Q));
            r4_r[2].im <= t_xy'(rshr(r3_cim[2] + r3_sim[3], ANG_Q));
            r4_r[3].re <= t_xy'(rshr(r3_cre[3] - r3_sre[2], ANG_Q));
            r4_r[3].im <= t_xy'(rshr(r3_cim[3] - r3_sim[2], ANG_Q));
            r4_z12 <= r3_z12;
            r4_z21 <= r3_z21;
        end
    end

    assign o_r   = r4_r;
    assign o_z12 = r4_z12;
    assign o_z21 = r4_z21;

endmodule
`default_nettype wire

// File: rtl/core/frpc_vec.sv
// Pipelined vectoring-mode CORDIC lane: gain-scaled magnitude and angle.
`timescale 1ns / 1ps
`default_nettype none
module frpc_vec import frpc_pkg::*; #(
    parameter int STAGES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cplx i_v,
    output t_xy        o_kmag,
    output t_ang       o_ang,
    output logic       o_zero
);

    t_xy  w_x [STAGES+1];
    t_xy  w_y [STAGES+1];
    t_ang w_z [STAGES+1];
    logic w_zr [STAGES+1];
    t_xy  r_px, r_py;
    t_ang r_pz;
    logic r_pzero;

    // prep: flag the zero vector, move left half-plane to the right
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pzero <= (i_v.re == '0) && (i_v.im == '0);
            if (i_v.re[XY_W-1]) begin
                r_px <= -i_v.re;
                r_py <= -i_v.im;
                r_pz <= i_v.im[XY_W-1] ? -PI_Q : PI_Q;
            end else begin
                r_px <= i_v.re;
                r_py <= i_v.im;
                r_pz <= '0;
            end
        end
    end

    assign w_x[0]  = r_px;
    assign w_y[0]  = r_py;
    assign w_z[0]  = r_pz;
    assign w_zr[0] = r_pzero;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_xy  r_x, r_y, n_x, n_y;
        t_ang r_z, n_z;
        logic r_zr;

        always_comb begin
            if (!w_y[g][XY_W-1]) begin
                n_x = w_x[g] + (w_y[g] >>> g);
                n_y = w_y[g] - (w_x[g] >>> g);
                n_z = w_z[g] + atan_q(g);
            end else begin
                n_x = w_x[g] - (w_y[g] >>> g);
                n_y = w_y[g] + (w_x[g] >>> g);
                n_z = w_z[g] - atan_q(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x  <= n_x;
                r_y  <= n_y;
                r_z  <= n_z;
                r_zr <= w_zr[g];
            end
        end

        assign w_x[g+1]  = r_x;
        assign w_y[g+1]  = r_y;
        assign w_z[g+1]  = r_z;
        assign w_zr[g+1] = r_zr;
    end

    assign o_kmag = w_x[STAGES];
    assign o_ang  = w_z[STAGES];
    assign o_zero = w_zr[STAGES];

endmodule
`default_nettype wire

// File: rtl/core/frpc_skid.sv
// Two-entry output buffer that decouples the pipeline from downstream backpressure.
`timescale 1ns / 1ps
`default_nettype none
module frpc_skid #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_room,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt, n_cnt;
    logic         w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/faraday_rotation_pixel_correct_unit.sv
// Faraday rotation correction of quad-pol pixels: top level, pipeline control and output stage.
// Throughput: one pixel per cycle; the whole pipeline advances together and holds only
//   while the two-entry output buffer is full.
// Reset (i_rst_n low, synchronous): pipeline valid bits and output buffer cleared,
//   correct_enable=1, use_single_angle=1, single_angle=0.
`timescale 1ns / 1ps
`default_nettype none
module faraday_rotation_pixel_correct_unit import frpc_pkg::*; #(
    parameter int AMP_WIDTH       = 16,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16,
    localparam int PH_W    = ANGLE_FRAC_BITS + 3,
    localparam int ANGW    = ANGLE_FRAC_BITS + 1,
    localparam int CH_W    = AMP_WIDTH + PH_W,
    localparam int IN_BITS = 4 * CH_W + ANGW,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 4 * CH_W + 2 * ANGW,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ANGW-1:0]      i_cfg_data,
    // pixel input
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata, low bit up: hh_amp_in, hh_arg_in, hv_amp_in, hv_arg_in, vh_amp_in,
    //   vh_arg_in, vv_amp_in, vv_arg_in, map_angle, zero pad
    input  wire logic [IN_W-1:0]      i_s_tdata,
    // corrected pixel output
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata, low bit up: hh_amp_out, hh_arg_out, hv_amp_out, hv_arg_out, vh_amp_out,
    //   vh_arg_out, vv_amp_out, vv_arg_out, angle_estimate, residual, zero pad
    output logic [OUT_W-1:0]          o_m_tdata
);

    localparam int SH_IN  = ANG_Q - ANGLE_FRAC_BITS;   // Q2.F to Q30
    localparam int SH_AMP = 58 - AMP_WIDTH;            // gain-corrected magnitude to amplitude
    localparam int SH_EST = 32 - ANGLE_FRAC_BITS;      // -1/4 and Q30 to Q2.F
    localparam int LAT    = 2 * CORDIC_STAGES + 11;    // register stages in the pipeline
    localparam int SIDE_D = LAT - 1;                   // side data taps the stage before output
    localparam int SIDE_W = 4 * CH_W + 1 + ANGW;
    localparam int PX_W   = AMP_WIDTH + 30;
    localparam t_prod AMP_MAX = (t_prod'(1) <<< AMP_WIDTH) - t_prod'(1);
    localparam logic [ANGW+1:0] RES_MAX = (ANGW + 2)'((1 << ANGW) - 1);

    typedef logic signed [ANGW-1:0] t_angle;

    // ---------------------------------------------------------------- config
    logic   r_cfg_en, r_cfg_single;
    t_angle r_cfg_angle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en     <= 1'b1;
            r_cfg_single <= 1'b1;
            r_cfg_angle  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CORRECT_ENABLE: r_cfg_en     <= i_cfg_data[0];
                CFG_USE_SINGLE:     r_cfg_single <= i_cfg_data[0];
                CFG_SINGLE_ANGLE:   r_cfg_angle  <= $signed(i_cfg_data);
                default: ;  // unmapped index, drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------- pipeline control
    // Every stage advances on w_en; the output buffer guarantees a free slot
    // for whatever leaves the last stage.
    logic           w_en, w_accept, w_push;
    logic [LAT-1:0] r_vld;

    assign w_accept   = i_s_tvalid && w_en;
    assign o_s_tready = w_en;
    assign w_push     = w_en && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // Raw fields, enable and applied angle travel beside the datapath for the
    // pass-through mux and the residual at the last stage.
    logic [SIDE_W-1:0] r_side [SIDE_D];
    logic [SIDE_W-1:0] w_side_in;
    t_angle            w_appl;

    always_comb begin
        if (!r_cfg_en) begin
            w_appl = '0;
        end else if (r_cfg_single) begin
            w_appl = r_cfg_angle;
        end else begin
            w_appl = $signed(i_s_tdata[4*CH_W +: ANGW]);
        end
        w_side_in = {i_s_tdata[4*CH_W-1:0], r_cfg_en, w_appl};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side_in;
            for (int k = 1; k < SIDE_D; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage 1: wrap phases
    logic [AMP_WIDTH-1:0] r1_amp [4];
    t_ang                 r1_ph  [4];
    t_angle               r1_appl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_amp[i] <= i_s_tdata[i*CH_W +: AMP_WIDTH];
                r1_ph[i]  <= wrap_pi(t_ang'($signed(i_s_tdata[i*CH_W+AMP_WIDTH +: PH_W]))
                                     <<< SH_IN);
            end
            r1_appl <= w_appl;
        end
    end

    // ---------------------------------------------------------------- stage 2: fold, scale
    // Lanes 0..3 are the channels, lane 4 makes cos/sin of the negated angle.
    t_xy            r2_x [5];
    t_ang           r2_z [5];
    logic [PX_W-1:0] w_px [4];
    t_xy            w_x0 [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_px[i] = PX_W'(r1_amp[i]) * PX_W'(INV_K_U);
            w_x0[i] = t_xy'(w_px[i] >> (AMP_WIDTH + 2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                if (r1_ph[i] > HALF_PI_Q) begin
                    r2_x[i] <= -w_x0[i];
                    r2_z[i] <= r1_ph[i] - PI_Q;
                end else if (r1_ph[i] < -HALF_PI_Q) begin
                    r2_x[i] <= -w_x0[i];
                    r2_z[i] <= r1_ph[i] + PI_Q;
                end else begin
                    r2_x[i] <= w_x0[i];
                    r2_z[i] <= r1_ph[i];
                end
            end
            r2_x[4] <= INV_K_Q;
            r2_z[4] <= -(t_ang'(r1_appl) <<< SH_IN);
        end
    end

    // ---------------------------------------------------------------- rotation CORDIC
    t_cplx w_rot [5];

    for (genvar g = 0; g < 5; g++) begin : g_rot
        frpc_rot #(
            .STAGES (CORDIC_STAGES)
        ) u_rot (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r2_x[g]),
            .i_z   (r2_z[g]),
            .o_v   (w_rot[g])
        );
    end

    // ---------------------------------------------------------------- matrix
    t_cplx w_m [4];
    t_cplx w_r [4];
    t_cplx w_z12, w_z21;

    assign w_m = w_rot[0:3];

    frpc_mat u_mat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_m   (w_m),
        .i_cs  (w_rot[4]),
        .o_r   (w_r),
        .o_z12 (w_z12),
        .o_z21 (w_z21)
    );

    // ---------------------------------------------------------------- vectoring CORDIC
    // Lanes 0..3 are the corrected entries, lanes 4 and 5 are z12 and z21.
    t_cplx w_vin  [6];
    t_xy   w_kmag [6];
    t_ang  w_vang [6];
    logic  w_vzero [6];

    assign w_vin[0] = w_r[0];
    assign w_vin[1] = w_r[1];
    assign w_vin[2] = w_r[2];
    assign w_vin[3] = w_r[3];
    assign w_vin[4] = w_z12;
    assign w_vin[5] = w_z21;

    for (genvar g = 0; g < 6; g++) begin : g_vec
        frpc_vec #(
            .STAGES (CORDIC_STAGES)
        ) u_vec (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_v    (w_vin[g]),
            .o_kmag (w_kmag[g]),
            .o_ang  (w_vang[g]),
            .o_zero (w_vzero[g])
        );
    end

    // ---------------------------------------------------------------- O1: gain, wrap
    t_prod r5_prod [4];
    t_ang  r5_ang  [6];
    logic  r5_nz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r5_prod[i] <= t_prod'(w_kmag[i]) * t_prod'(INV_K_Q);
            end
            for (int i = 0; i < 6; i++) begin
                r5_ang[i] <= w_vzero[i] ? '0 : wrap_pi(w_vang[i]);
            end
            r5_nz <= !w_vzero[4] && !w_vzero[5];
        end
    end

    // ---------------------------------------------------------------- O2: round, saturate
    logic [AMP_WIDTH-1:0] r6_amp [4];
    logic [PH_W-1:0]      r6_ph  [4];
    t_ang                 r6_d;
    t_prod                w_a  [4];
    t_prod                w_ph [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_a[i]  = rshr(r5_prod[i], SH_AMP);
            w_ph[i] = rshr(t_prod'(r5_ang[i]), SH_IN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                if (w_a[i][PROD_W-1]) begin
                    r6_amp[i] <= '0;
                end else if (w_a[i] > AMP_MAX) begin
                    r6_amp[i] <= AMP_MAX[AMP_WIDTH-1:0];
                end else begin
                    r6_amp[i] <= w_a[i][AMP_WIDTH-1:0];
                end
                r6_ph[i] <= w_ph[i][PH_W-1:0];
            end
            // estimate is zero when either term vanishes
            r6_d <= r5_nz ? wrap_pi(r5_ang[4] - r5_ang[5]) : '0;
        end
    end

    // ---------------------------------------------------------------- O3: estimate
    logic [AMP_WIDTH-1:0] r7_amp [4];
    logic [PH_W-1:0]      r7_ph  [4];
    t_angle               r7_est;
    t_prod                w_est;

    assign w_est = rshr(-t_prod'(r6_d), SH_EST);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_amp <= r6_amp;
            r7_ph  <= r6_ph;
            r7_est <= w_est[ANGW-1:0];
        end
    end

    // ---------------------------------------------------------------- O4: residual, select
    logic [SIDE_W-1:0]     w_side;
    logic                  w_side_en;
    t_angle                w_side_appl;
    logic signed [ANGW+1:0] w_diff;
    logic [ANGW+1:0]       w_mag;
    logic [ANGW-1:0]       w_res;
    logic [OUT_BITS-1:0]   w_fields;
    logic [OUT_W-1:0]      r8_data, w_pack;

    always_comb begin
        w_side      = r_side[SIDE_D-1];
        w_side_appl = $signed(w_side[ANGW-1:0]);
        w_side_en   = w_side[ANGW];
        w_diff      = -(ANGW + 2)'(w_side_appl) - (ANGW + 2)'(r7_est);
        w_mag       = w_diff[ANGW+1] ? (ANGW + 2)'(-w_diff) : (ANGW + 2)'(w_diff);
        w_res       = (w_mag > RES_MAX) ? RES_MAX[ANGW-1:0] : w_mag[ANGW-1:0];
        // disabled: pass the raw pixel through, keep estimate and residual
        if (w_side_en) begin
            for (int i = 0; i < 4; i++) begin
                w_fields[i*CH_W +: CH_W] = {r7_ph[i], r7_amp[i]};
            end
        end else begin
            w_fields[4*CH_W-1:0] = w_side[ANGW+1 +: 4*CH_W];
        end
        w_fields[4*CH_W +: ANGW]        = r7_est;
        w_fields[4*CH_W + ANGW +: ANGW] = w_res;
        w_pack                  = '0;
        w_pack[OUT_BITS-1:0]    = w_fields;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_data <= w_pack;
        end
    end

    // ---------------------------------------------------------------- output buffer
    frpc_skid #(
        .W (OUT_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (r8_data),
        .o_room  (w_en),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

    // ---------------------------------------------------------------- assertions
    // a held pipeline must not gain or lose items
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a hold");

    // a vanishing z12 or z21 forces a zero estimate difference
    a_zero_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && !r5_nz |=> r6_d == '0)
        else $error("estimate not zeroed for a zero term");

    // a result pushed from the last stage must show as valid at the buffer output
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_m_tvalid)
        else $error("pushed result not shown at output");

endmodule
`default_nettype wire
